// ----- design/khrb_pkg.sv -----
// ----------------------------------------------------------------------------
// khrb_pkg
// Shared types and constants of the keyboard HID report builder.
// ----------------------------------------------------------------------------
`default_nettype none
package khrb_pkg;
    localparam logic [15:0] USAGE_MIN = 16'h0004;
    localparam logic [15:0] USAGE_MAX = 16'h00E7;
    localparam logic [15:0] MOD_FIRST = 16'h00E0;
    localparam logic [15:0] HOLD_RESET = 16'd200;
    localparam int          BMP_BYTES = 29;
    localparam int          BMP_LEN = 30;
    localparam int          SIX_LEN = 8;
    localparam logic [1:0]  CFG_TOGGLE_CODE = 2'd0;
    localparam logic [1:0]  CFG_TOGGLE_HOLD = 2'd1;
    localparam logic [1:0]  CFG_MODE = 2'd2;
    localparam logic [1:0]  ID_SIX = 2'd1;
    localparam logic [1:0]  ID_BMP = 2'd2;

    typedef struct packed {
        logic       clear;    // start of tick: clear accumulators
        logic       scan;     // scan current column
        logic       compare;  // compare current report with stored copy
        logic       commit;   // store report copy
        logic       emit;     // output byte at emit index
    } t_cmd;

    typedef struct packed {
        logic       differs;
        logic       mode;
    } t_status;
endpackage
`default_nettype wire

// ----- design/khrb_if.sv -----
// ----------------------------------------------------------------------------
// khrb_in_if / khrb_out_if
// Valid/ready channels of the report builder.
// ----------------------------------------------------------------------------
`default_nettype none
interface khrb_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [5:0]  column;
    logic        key_down;
    logic [15:0] keycode;
    logic        host_ready;
    modport source(output valid, cmd, column, key_down, keycode, host_ready, input ready);
    modport sink(input valid, cmd, column, key_down, keycode, host_ready, output ready);
endinterface

interface khrb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  report_id;
    logic [4:0]  byte_index;
    logic [7:0]  byte_value;
    logic        last;
    modport source(output valid, report_id, byte_index, byte_value, last, input ready);
    modport sink(input valid, report_id, byte_index, byte_value, last, output ready);
endinterface
`default_nettype wire

// ----- design/khrb_datapath.sv -----
// ----------------------------------------------------------------------------
// khrb_datapath
// Key table, scan accumulators, stored reports and mode/toggle timing.
// ----------------------------------------------------------------------------
`default_nettype none
module khrb_datapath
    import khrb_pkg::*;
#(
    parameter int KEY_COLUMNS = 16,
    parameter int CW = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          i_key_we,
    input  wire logic [5:0]    i_key_col,
    input  wire logic          i_key_down,
    input  wire logic [15:0]   i_key_code,
    input  wire t_cmd          i_cmd,
    input  wire logic [CW-1:0] i_col,
    input  wire logic [4:0]    i_idx,
    output t_status            o_status,
    output logic [7:0]         o_byte
);
    logic [KEY_COLUMNS-1:0] r_pressed;
    logic [15:0]            r_code [KEY_COLUMNS];
    logic [15:0]            r_toggle_code, r_toggle_hold;
    logic                   r_mode;
    logic [31:0]            r_tick, r_last_toggle;
    logic [7:0]             r_mods;
    logic [2:0]             r_nsix;
    logic [7:0]             r_six [6];
    logic [231:0]           r_bmp;
    logic [63:0]            r_last_six;
    logic [7:0]             r_last_bmp [BMP_LEN];
    logic [7:0]             cur_bmp [BMP_LEN];
    logic [63:0]            cur_six;
    logic [15:0]            kc;
    logic [7:0]             boff;
    logic                   act;

    assign kc  = r_code[i_col];
    assign act = r_pressed[i_col] && kc != 16'd0 && kc != 16'd1;
    assign boff = 8'(kc - USAGE_MIN);

    always_comb begin
        cur_six = {r_six[5], r_six[4], r_six[3], r_six[2], r_six[1], r_six[0], 8'd0, r_mods};
        cur_bmp[0] = r_mods;
        for (int b = 0; b < BMP_BYTES; b++) cur_bmp[b+1] = r_bmp[8*b +: 8];
    end

    always_comb begin
        o_status.mode    = r_mode;
        o_status.differs = 1'b0;
        if (r_mode) begin
            for (int b = 0; b < BMP_LEN; b++)
                if (cur_bmp[b] != r_last_bmp[b]) o_status.differs = 1'b1;
        end else begin
            o_status.differs = (cur_six != r_last_six);
        end
    end

    always_comb begin
        if (r_mode) o_byte = (i_idx < 5'(BMP_LEN)) ? r_last_bmp[i_idx] : 8'd0;
        else o_byte = (i_idx < 5'(SIX_LEN)) ? r_last_six[8*i_idx[2:0] +: 8] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed     <= '0;
            r_toggle_code <= 16'd0;
            r_toggle_hold <= HOLD_RESET;
            r_mode        <= 1'b0;
            r_tick        <= 32'd0;
            r_last_toggle <= 32'd0;
            r_last_six    <= 64'd0;
            for (int i = 0; i < KEY_COLUMNS; i++) r_code[i] <= 16'd0;
            for (int b = 0; b < BMP_LEN; b++) r_last_bmp[b] <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOGGLE_CODE: r_toggle_code <= i_cfg_data;
                    CFG_TOGGLE_HOLD: r_toggle_hold <= i_cfg_data;
                    CFG_MODE: begin
                        r_mode <= i_cfg_data[0];
                    end
                    default: ;
                endcase
            end
            if (i_key_we && {1'b0, i_key_col} < 7'(KEY_COLUMNS)) begin
                r_pressed[CW'(i_key_col)] <= i_key_down;
                r_code[CW'(i_key_col)]    <= i_key_down ? i_key_code : 16'd0;
            end
            if (i_cmd.clear) r_tick <= r_tick + 32'd1;
            if (i_cmd.scan && act && kc == r_toggle_code
                && (r_tick - r_last_toggle) > {16'd0, r_toggle_hold}) begin
                r_mode        <= ~r_mode;
                r_last_toggle <= r_tick;
            end
            if (i_cmd.commit) begin
                if (r_mode) for (int b = 0; b < BMP_LEN; b++) r_last_bmp[b] <= cur_bmp[b];
                else r_last_six <= cur_six;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mods <= 8'd0;
            r_nsix <= 3'd0;
            r_bmp  <= '0;
            for (int s = 0; s < 6; s++) r_six[s] <= 8'd0;
        end else if (i_cmd.scan && act) begin
            if (kc >= MOD_FIRST && kc <= USAGE_MAX) r_mods[kc[2:0]] <= 1'b1;
            if (kc < MOD_FIRST && r_nsix < 3'd6) begin
                r_six[r_nsix] <= kc[7:0];
                r_nsix        <= r_nsix + 3'd1;
            end
            if (kc >= USAGE_MIN && kc <= USAGE_MAX) r_bmp[boff] <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// ----- design/khrb_ctrl.sv -----
// ----------------------------------------------------------------------------
// khrb_ctrl
// Sequencer: accept, column scan, compare/commit and byte emission.
// ----------------------------------------------------------------------------
`default_nettype none
module khrb_ctrl
    import khrb_pkg::*;
#(
    parameter int KEY_COLUMNS = 16,
    parameter int CW = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_cmd,
    input  wire logic          i_in_host_ready,
    output logic               o_in_ready,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic               o_out_last,
    output logic [1:0]         o_out_id,
    input  wire t_status       i_status,
    output t_cmd               o_cmd,
    output logic [CW-1:0]      o_col,
    output logic [4:0]         o_idx
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_CMP = 3'd2, S_EMIT = 3'd3;
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [4:0]    r_idx, n_idx;
    logic          r_host, n_host;
    logic [4:0]    lastidx;

    assign lastidx  = i_status.mode ? 5'(BMP_LEN - 1) : 5'(SIX_LEN - 1);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_last = (r_idx == lastidx);
    assign o_out_id = i_status.mode ? ID_BMP : ID_SIX;
    assign o_col = r_col;
    assign o_idx = r_idx;

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_idx   = r_idx;
        n_host  = r_host;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_cmd) begin
                    o_cmd.clear = 1'b1;
                    n_col   = '0;
                    n_host  = i_in_host_ready;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_col = r_col + 1'b1;
                if (r_col == CW'(KEY_COLUMNS - 1)) n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_idx = 5'd0;
                if (i_status.differs) begin
                    o_cmd.commit = 1'b1;
                    n_state = r_host ? S_EMIT : S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_idx = r_idx + 5'd1;
                    if (r_idx == lastidx) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_idx   <= 5'd0;
            r_host  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_idx   <= n_idx;
            r_host  <= n_host;
        end
    end
endmodule
`default_nettype wire

// ----- design/keyboard_hid_report_builder.sv -----
// ----------------------------------------------------------------------------
// keyboard_hid_report_builder
// Six-key / bitmap HID keyboard report builder.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in       in   cmd, column, key_down, keycode, host_ready
// out      out  report_id, byte_index, byte_value, last
// cfg      in   we, idx, data (16 bits)
// key event: taken while idle. tick: clear, a scan of each column, a compare,
// then 8 or 30 byte transfers if the report changed and host_ready was set,
// one a cycle while out.ready is high. The scan and the byte emission dominate.
// synchronous active-low reset; stored reports and key table cleared at once.
// ----------------------------------------------------------------------------
`default_nettype none
module keyboard_hid_report_builder
    import khrb_pkg::*;
#(
    parameter int KEY_COLUMNS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    khrb_in_if.sink          in_ch,
    khrb_out_if.source       out_ch
);
    localparam int CW = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1;
    t_cmd          cmd;
    t_status       status;
    logic [CW-1:0] col;
    logic [4:0]    idx;

    khrb_ctrl #(.KEY_COLUMNS(KEY_COLUMNS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_cmd(in_ch.cmd),
        .i_in_host_ready(in_ch.host_ready), .o_in_ready(in_ch.ready),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid),
        .o_out_last(out_ch.last), .o_out_id(out_ch.report_id),
        .i_status(status), .o_cmd(cmd), .o_col(col), .o_idx(idx)
    );

    khrb_datapath #(.KEY_COLUMNS(KEY_COLUMNS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_key_we(in_ch.valid && in_ch.ready && !in_ch.cmd),
        .i_key_col(in_ch.column), .i_key_down(in_ch.key_down),
        .i_key_code(in_ch.keycode),
        .i_cmd(cmd), .i_col(col), .i_idx(idx),
        .o_status(status), .o_byte(out_ch.byte_value)
    );
    assign out_ch.byte_index = idx;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken during emit");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear, cmd.scan, cmd.emit})) else $error("command overlap");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> idx < 5'(BMP_LEN)) else $error("byte index out of range");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.ready && out_ch.last |=> !out_ch.valid)
        else $error("emit after last");
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the keyboard HID report builder: key events and
// report ticks go in through the input channel, the expected report bytes are
// worked out by a scan model in the bench and checked in order on the output.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    import khrb_pkg::*;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  column;
        logic        key_down;
        logic [15:0] keycode;
        logic        host_ready;
    } t_key_item;

    typedef struct packed {
        logic [1:0] report_id;
        logic [4:0] byte_index;
        logic [7:0] byte_value;
        logic       last;
    } t_report_byte;

    localparam int NCOL = 16;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    khrb_in_if in_ch ();
    khrb_out_if out_ch ();

    keyboard_hid_report_builder #(.KEY_COLUMNS(NCOL)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // bench copy of the block state
    logic [15:0] m_toggle_code = '0;
    logic [15:0] m_hold = HOLD_RESET;
    logic        m_mode_reset = 1'b0;
    logic        m_pressed [NCOL];
    logic [15:0] m_code [NCOL];
    logic [63:0] m_last_six = '0;
    logic [7:0]  m_last_bmp [BMP_LEN];
    logic        m_mode = 1'b0;
    logic [31:0] m_ticks = '0;
    logic [31:0] m_last_toggle = '0;

    t_key_item pending_items[$];
    t_report_byte expected_bytes[$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    int quiet_cycles = 0;
    logic in_taken = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TOGGLE_CODE: m_toggle_code = val;
            CFG_TOGGLE_HOLD: m_hold = val;
            CFG_MODE: begin
                m_mode_reset = val[0];
                m_mode = val[0];
            end
            default: ;
        endcase
    endtask

    task automatic build_report(input t_key_item it);
        logic [7:0] mods;
        logic [7:0] six [6];
        logic [7:0] cur [BMP_LEN];
        logic [63:0] six_word;
        int nsix;
        int b;
        logic [15:0] kc;
        logic differs;
        t_report_byte rb;
        if (!it.cmd) begin
            if (it.column < NCOL) begin
                m_pressed[it.column] = it.key_down;
                m_code[it.column] = it.key_down ? it.keycode : 16'h0;
            end
            return;
        end
        m_ticks = m_ticks + 32'd1;
        mods = '0;
        nsix = 0;
        for (int k = 0; k < 6; k++) six[k] = '0;
        for (int k = 0; k < BMP_LEN; k++) cur[k] = '0;
        for (int c = 0; c < NCOL; c++) begin
            kc = m_code[c];
            if (!m_pressed[c] || kc == 0 || kc == 1) continue;
            if (kc >= MOD_FIRST && kc <= USAGE_MAX) mods[kc - MOD_FIRST] = 1'b1;
            if (kc < MOD_FIRST && nsix < 6) begin
                six[nsix] = kc[7:0];
                nsix++;
            end
            if (kc >= USAGE_MIN && kc <= USAGE_MAX) begin
                b = kc - USAGE_MIN;
                cur[1 + b / 8][b % 8] = 1'b1;
            end
            if (kc == m_toggle_code && (m_ticks - m_last_toggle) > {16'h0, m_hold}) begin
                m_mode = ~m_mode;
                m_last_toggle = m_ticks;
            end
        end
        cur[0] = mods;
        if (m_mode) begin
            differs = 1'b0;
            for (int k = 0; k < BMP_LEN; k++) if (cur[k] != m_last_bmp[k]) differs = 1'b1;
            if (differs) begin
                for (int k = 0; k < BMP_LEN; k++) m_last_bmp[k] = cur[k];
                if (it.host_ready) for (int k = 0; k < BMP_LEN; k++) begin
                    rb = '{ID_BMP, 5'(k), cur[k], k == BMP_LEN - 1};
                    expected_bytes.push_back(rb);
                end
            end
        end else begin
            six_word = {six[5], six[4], six[3], six[2], six[1], six[0], 8'h00, mods};
            if (six_word != m_last_six) begin
                m_last_six = six_word;
                if (it.host_ready) for (int k = 0; k < SIX_LEN; k++) begin
                    rb = '{ID_SIX, 5'(k), six_word[8 * k +: 8], k == SIX_LEN - 1};
                    expected_bytes.push_back(rb);
                end
            end
        end
    endtask

    // transfer seen at the last rising edge
    always @(posedge i_clk) begin
        in_taken <= in_ch.valid && in_ch.ready;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            {in_ch.cmd, in_ch.column, in_ch.key_down, in_ch.keycode, in_ch.host_ready} <= '0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                t_key_item it;
                it = pending_items.pop_front();
                in_ch.valid <= 1'b1;
                {in_ch.cmd, in_ch.column, in_ch.key_down, in_ch.keycode, in_ch.host_ready} <= it;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            out_ch.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_report_byte got;
        t_report_byte want;
        logic busy;
        if (i_rst_n) begin
            busy = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                build_report({in_ch.cmd, in_ch.column, in_ch.key_down, in_ch.keycode,
                              in_ch.host_ready});
                busy = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                busy = 1'b1;
                got = '{out_ch.report_id, out_ch.byte_index, out_ch.byte_value, out_ch.last};
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h", got));
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.report_id != want.report_id)
                        report_mismatch($sformatf("report_id %0d, want %0d",
                                                  got.report_id, want.report_id));
                    if (got.byte_index != want.byte_index)
                        report_mismatch($sformatf("byte_index %0d, want %0d",
                                                  got.byte_index, want.byte_index));
                    if (got.byte_value != want.byte_value)
                        report_mismatch($sformatf("byte %0d value %h, want %h",
                                                  want.byte_index, got.byte_value,
                                                  want.byte_value));
                    if (got.last != want.last)
                        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
                end
            end
            quiet_cycles <= busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("keyboard_hid_report_builder regression: fail");
                $finish;
            end
        end
    end

    function automatic t_key_item key_item(input logic [5:0] col, input logic dn,
                                           input logic [15:0] kc);
        return '{1'b0, col, dn, kc, 1'($urandom_range(1))};
    endfunction

    function automatic t_key_item tick_item(input logic rdy);
        return '{1'b1, 6'($urandom_range(63)), 1'($urandom_range(1)), 16'($urandom), rdy};
    endfunction

    function automatic logic [15:0] random_code();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'($urandom_range(1));
            2, 3: return 16'($urandom_range(8'hE7, 8'hE0));
            4: return 16'($urandom_range(16'hFFFF, 16'hE8));
            default: return 16'($urandom_range(8'hDF, 8'h04));
        endcase
    endfunction

    task automatic drain();
        while (pending_items.size() != 0 || in_ch.valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n, input int idle, input int stall);
        logic [5:0] col;
        idle_pct = idle;
        stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 45) begin
                pending_items.push_back(tick_item($urandom_range(99) < 85));
            end else begin
                col = $urandom_range(99) < 90 ? 6'($urandom_range(NCOL - 1))
                                              : 6'($urandom_range(63));
                pending_items.push_back(key_item(col, $urandom_range(99) < 60,
                                                 random_code()));
            end
        end
        drain();
    endtask

    initial begin
        for (int c = 0; c < NCOL; c++) begin
            m_pressed[c] = 1'b0;
            m_code[c] = '0;
        end
        for (int k = 0; k < BMP_LEN; k++) m_last_bmp[k] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: six-key mode, slots, overflow, modifiers, odd codes
        pending_items.push_back(key_item(6'd0, 1'b1, 16'h0004));
        pending_items.push_back(key_item(6'd15, 1'b1, 16'h00E0));
        pending_items.push_back(key_item(6'd3, 1'b1, 16'h00E7));
        pending_items.push_back(tick_item(1'b1));
        for (int c = 4; c < 11; c++)
            pending_items.push_back(key_item(6'(c), 1'b1, 16'(8'hD0 + c)));
        pending_items.push_back(key_item(6'd1, 1'b1, 16'h0001));
        pending_items.push_back(key_item(6'd2, 1'b1, 16'hFFFF));
        pending_items.push_back(key_item(6'd63, 1'b1, 16'h0005));
        pending_items.push_back(tick_item(1'b1));
        pending_items.push_back(tick_item(1'b1));
        pending_items.push_back(key_item(6'd0, 1'b0, 16'hFFFF));
        pending_items.push_back(tick_item(1'b0));
        pending_items.push_back(tick_item(1'b1));
        for (int c = 0; c < NCOL; c++) pending_items.push_back(key_item(6'(c), 1'b0, 16'h0));
        pending_items.push_back(tick_item(1'b1));
        drain();

        // bitmap mode, toggle with no hold
        write_reg(CFG_MODE, 16'h0001);
        write_reg(CFG_TOGGLE_HOLD, 16'h0000);
        write_reg(CFG_TOGGLE_CODE, 16'h00F0);
        pending_items.push_back(key_item(6'd5, 1'b1, 16'h00DF));
        pending_items.push_back(key_item(6'd6, 1'b1, 16'h00E5));
        pending_items.push_back(tick_item(1'b1));
        pending_items.push_back(key_item(6'd7, 1'b1, 16'h00F0));
        pending_items.push_back(tick_item(1'b1));
        pending_items.push_back(tick_item(1'b1));
        pending_items.push_back(tick_item(1'b1));
        drain();

        // receiver holds off while the sender keeps going
        hold_off = 400;
        random_phase(60, 0, 0);
        // sender pauses until everything is out
        random_phase(60, 0, 0);

        write_reg(CFG_TOGGLE_HOLD, 16'hFFFF);
        write_reg(CFG_TOGGLE_CODE, 16'h0000);
        write_reg(CFG_MODE, 16'h0000);
        write_reg(2'd3, 16'hFFFF);
        random_phase(80, 76, 0);
        write_reg(CFG_TOGGLE_HOLD, 16'd3);
        write_reg(CFG_TOGGLE_CODE, 16'h00E2);
        random_phase(80, 0, 76);
        write_reg(CFG_TOGGLE_CODE, 16'h0001);
        write_reg(CFG_MODE, 16'h0001);
        random_phase(80, 26, 26);
        write_reg(CFG_TOGGLE_HOLD, 16'd1);
        write_reg(CFG_TOGGLE_CODE, 16'h0010);
        random_phase(60, 0, 0);

        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("keyboard_hid_report_builder regression: pass");
        end else begin
            $display("keyboard_hid_report_builder regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
